[hw/rtl/ostt_pkg.sv]
package ostt_pkg;

  localparam int DEF_NUM_SLOTS = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_IDLE   = 2'd3;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_FREE = 1'b1;

  // result select codes, controller to datapath
  localparam logic [2:0] OSEL_NONE        = 3'd0;
  localparam logic [2:0] OSEL_CREATE_OK   = 3'd1;
  localparam logic [2:0] OSEL_CREATE_FAIL = 3'd2;
  localparam logic [2:0] OSEL_CANCEL      = 3'd3;
  localparam logic [2:0] OSEL_PEND        = 3'd4;
  localparam logic [2:0] OSEL_IDLE        = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] elapsed_ms;
    logic [31:0] duration_ms;
    logic        has_action;
    logic [31:0] cancel_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] result_id;
    logic [2:0]  slot_index;
    logic [3:0]  active_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic       load;     // capture item fields
    logic       tick;     // advance millisecond count on load
    logic       alloc;    // take slot at scan index
    logic       free_s;   // release slot at scan index
    logic       pend_wr;  // hold expiry of slot at scan index
    logic [2:0] osel;     // result to register this cycle
    logic       last;     // last flag for a held expiry
  } cmd_t;

  typedef struct packed {
    logic hit_free;
    logic hit_cancel;
    logic hit_expire;
  } sts_t;

endpackage

[hw/rtl/ostt_ctrl.sv]
module ostt_ctrl #(
  parameter int NUM_SLOTS = ostt_pkg::DEF_NUM_SLOTS,
  parameter int IDX_W     = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_op,
  input  ostt_pkg::sts_t    sts,
  output logic              busy,
  output ostt_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0]  idx
);
  import ostt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);
  localparam logic [RES_CNT_W-1:0] N_MAX = RES_CNT_W'(MAX_RESULTS);

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;
  logic                 at_last;

  assign busy    = (state_r != S_IDLE);
  assign idx     = idx_r;
  assign at_last = (idx_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    cmd       = '0;
    cmd.osel  = OSEL_NONE;
    case (state_r)
      S_IDLE: begin
        if (start && (in_op inside {OP_TICK, OP_CREATE, OP_CANCEL})) begin
          cmd.load  = 1'b1;
          cmd.tick  = (in_op == OP_TICK);
          mode_nxt  = in_op;
          idx_nxt   = '0;
          n_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        case (mode_r)
          OP_CREATE: begin
            if (sts.hit_free) begin
              cmd.alloc = 1'b1;
              cmd.osel  = OSEL_CREATE_OK;
              state_nxt = S_IDLE;
            end else if (at_last) begin
              cmd.osel  = OSEL_CREATE_FAIL;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          OP_CANCEL: begin
            cmd.free_s = sts.hit_cancel;
            if (at_last) begin
              cmd.osel  = OSEL_CANCEL;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: begin
            if (sts.hit_expire) begin
              cmd.free_s  = 1'b1;
              cmd.pend_wr = 1'b1;
              if (n_r != '0) begin
                cmd.osel = OSEL_PEND;
              end
              n_nxt = n_r + 1'b1;
            end
            if (at_last || (sts.hit_expire && n_nxt == N_MAX)) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        endcase
      end
      S_FLUSH: begin
        cmd.last  = 1'b1;
        cmd.osel  = (n_r != '0) ? OSEL_PEND : OSEL_IDLE;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= OP_TICK;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cmd.osel == OSEL_NONE && !cmd.alloc && !cmd.free_s))
    else $error("datapath command issued while idle");
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_MAX)
    else $error("expiry count above limit");
  a_flush_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |=> (state_r == S_IDLE))
    else $error("flush did not return to idle");
`endif

endmodule

[hw/rtl/ostt_dpath.sv]
module ostt_dpath #(
  parameter int NUM_SLOTS = ostt_pkg::DEF_NUM_SLOTS,
  parameter int IDX_W     = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ostt_pkg::in_t     in_data,
  input  ostt_pkg::cmd_t    cmd,
  input  logic [IDX_W-1:0]  idx,
  output ostt_pkg::sts_t    sts,
  output logic              out_valid,
  output ostt_pkg::out_t    out_data
);
  import ostt_pkg::*;

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic                 busy_r  [NUM_SLOTS];
  logic                 act_r   [NUM_SLOTS];
  logic [31:0]          start_r [NUM_SLOTS];
  logic [31:0]          dur_r   [NUM_SLOTS];
  logic [31:0]          ident_r [NUM_SLOTS];

  logic [31:0]          now_r;
  logic [31:0]          id_seq_r, id_seq_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic [31:0]          dur_in_r;
  logic                 act_in_r;
  logic [31:0]          cid_r;

  logic [31:0]          pend_id_r;
  logic [2:0]           pend_slot_r;
  logic [3:0]           pend_count_r;

  logic                 out_valid_r;
  out_t                 out_r;

  logic [31:0]          age;
  logic [31:0]          idx_ext;
  logic [2:0]           slot3;
  logic [3:0]           cnt4, cnt4_nxt;
  logic [31:0]          cnt_ext, cnt_nxt_ext;

  assign age         = now_r - start_r[idx];
  assign idx_ext     = 32'(idx);
  assign slot3       = idx_ext[2:0];
  assign cnt_ext     = 32'(count_r);
  assign cnt_nxt_ext = 32'(count_nxt);
  assign cnt4        = cnt_ext[3:0];
  assign cnt4_nxt    = cnt_nxt_ext[3:0];

  assign sts.hit_free   = !busy_r[idx];
  assign sts.hit_cancel = (cid_r != '0) && busy_r[idx] && (ident_r[idx] == cid_r);
  assign sts.hit_expire = busy_r[idx] && act_r[idx] && (age >= dur_r[idx]);

  always_comb begin
    count_nxt = count_r;
    if (cmd.alloc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.free_s && count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end
    id_seq_nxt = id_seq_r;
    if (cmd.alloc) begin
      id_seq_nxt = (id_seq_r == 32'hFFFF_FFFF) ? 32'd1 : id_seq_r + 32'd1;
    end
  end

  // control and slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        busy_r[i] <= 1'b0;
        act_r[i]  <= 1'b0;
      end
      now_r       <= '0;
      id_seq_r    <= 32'd1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && cmd.tick) begin
        now_r <= now_r + 32'(in_data.elapsed_ms);
      end
      if (cmd.alloc) begin
        busy_r[idx] <= 1'b1;
        act_r[idx]  <= act_in_r;
      end else if (cmd.free_s) begin
        busy_r[idx] <= 1'b0;
        act_r[idx]  <= 1'b0;
      end
      id_seq_r    <= id_seq_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (cmd.osel != OSEL_NONE);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_in_r <= in_data.duration_ms;
      act_in_r <= in_data.has_action;
      cid_r    <= in_data.cancel_id;
    end
    if (cmd.alloc) begin
      start_r[idx] <= now_r;
      dur_r[idx]   <= dur_in_r;
      ident_r[idx] <= id_seq_r;
    end
    if (cmd.pend_wr) begin
      pend_id_r    <= ident_r[idx];
      pend_slot_r  <= slot3;
      pend_count_r <= cnt4_nxt;
    end
    case (cmd.osel)
      OSEL_CREATE_OK:   out_r <= '{KIND_CREATE, ST_OK, id_seq_r, slot3, cnt4_nxt, 1'b1};
      OSEL_CREATE_FAIL: out_r <= '{KIND_CREATE, ST_NO_FREE, 32'd0, 3'd0, cnt4, 1'b1};
      OSEL_CANCEL:      out_r <= '{KIND_CANCEL, ST_OK, 32'd0, 3'd0, cnt4_nxt, 1'b1};
      OSEL_PEND:        out_r <= '{KIND_EXPIRY, ST_OK, pend_id_r, pend_slot_r, pend_count_r,
                                   cmd.last};
      OSEL_IDLE:        out_r <= '{KIND_IDLE, ST_OK, 32'd0, 3'd0, cnt4, 1'b1};
      default:          out_r <= out_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= NUM_SLOTS)
    else $error("busy count above slot count");
  a_alloc_free_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.alloc && cmd.free_s))
    else $error("alloc and free in one cycle");
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |=> (count_r == $past(count_r) + 1'b1))
    else $error("alloc did not bump busy count");
  a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !busy_r[idx])
    else $error("alloc into busy slot");
`endif

endmodule

[hw/rtl/one_shot_timer_table.sv]
// One-shot millisecond timer table.
//
// Input channel: drive in_data with start high; the item transfers at a
// rising edge where start is high and busy is low. op 0 ticks (adds
// elapsed_ms to the millisecond count, then reports expiries), op 1
// creates a timer in the lowest free slot, op 2 cancels by id. op 3 is
// dropped with no result.
// Result channel: each result is on out_data for one cycle with out_valid
// high; the receiver takes it and cannot stall. A tick gives one result
// per expired slot (up to MAX_RESULTS), or one idle result; the final
// result of each item has last set.
// Scan: a controller walks the slots one per cycle through a single
// shared compare unit. Create stops at the first free slot and reports
// failure if none is free; cancel walks every slot, and tick walks every
// slot or stops at MAX_RESULTS expiries. Each expiry report is held
// until the scan finds the next expiry or ends, so reports come out as
// the scan proceeds. busy drops in the cycle the last result is shown,
// so the next item can transfer while it is on the bus.
// Reset (rst_n low, synchronous) frees all slots, clears the millisecond
// count and restarts ids at 1.
module one_shot_timer_table #(
  parameter int NUM_SLOTS = ostt_pkg::DEF_NUM_SLOTS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ostt_pkg::in_t   in_data,
  output logic            out_valid,
  output ostt_pkg::out_t  out_data
);
  import ostt_pkg::*;

  // scan index width, at least one bit for a single-slot table
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] idx;

  // sequencer: scan index, item kind, expiry count
  ostt_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_data.op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd),
    .idx   (idx)
  );

  // slot store, counters, held expiry and result register
  ostt_dpath #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .idx       (idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
